[rtl/ffea_pkg.sv]
// Package: shared types, constants and codes for the first-fit extent allocator.
`default_nettype none
package ffea_pkg;
	localparam int MAX_EXTENTS = 16;
	localparam int IDX_W = $clog2(MAX_EXTENTS);
	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
	localparam logic [31:0] HDR = 32'd4;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	localparam logic [0:0] REG_BASE  = 1'b0;
	localparam logic [0:0] REG_BYTES = 1'b1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic        command;
		logic [31:0] request_bytes;
		logic [31:0] free_pointer;
		logic [31:0] free_block_bytes;
	} in_word_t;

	typedef struct packed {
		logic [31:0] user_pointer;
		logic [31:0] granted_bytes;
		logic [1:0]  status;
	} out_word_t;

	// datapath operations selected by the controller
	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_INIT, OP_PREV, OP_CUR, OP_CARVE, OP_SHIFT,
		OP_SETLEN, OP_SETBOTH, OP_SETNEXT, OP_PUT, OP_DEC, OP_NOFIT, OP_FULL,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t  op;
		idx_t idx;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic need_ovf;
		logic size_zero;
		logic fit;        // entry just read can hold the request
		logic below;      // entry just read starts below the free address
		logic prev_touch; // previous entry merges with the block
		logic next_touch; // next entry merges with the block
		logic chain;      // after prev merge, next merges too
		logic empty_after;
		cnt_t count;
	} sts_t;
endpackage
`default_nettype wire

[rtl/first_fit_extent_allocator.sv]
// Top level of the first-fit extent allocator.
`default_nettype none
// First-fit free-extent allocator. Writing either heap register reloads the
// table with a single extent covering the heap (none if the size is zero)
// before the next word is taken. Each word (allocate or free) is handled alone.
// The extent table memories have one read and one write port with registered
// read, so every table entry that is scanned or shifted costs a read state and
// a check or write state. The result sits in an output register; a new word
// is taken while it waits, but that word's result is held until the output
// register is free.
module first_fit_extent_allocator (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [0:0]           cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire ffea_pkg::in_word_t   in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output ffea_pkg::out_word_t       out_data
);
	ffea_pkg::cmd_t cmd;
	ffea_pkg::sts_t sts;

	ffea_ctrl u_ctrl (
		.clk, .arst_n, .cfg_we, .in_valid, .in_stall,
		.out_valid, .out_stall, .sts, .cmd);

	ffea_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_idx(cfg_index), .cfg_data,
		.in_word(in_data), .cmd, .sts, .res(out_data));
endmodule
`default_nettype wire

[rtl/ffea_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ffea_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[rtl/ffea_datapath.sv]
// Datapath: extent table memories, address/size arithmetic and result word.
`default_nettype none
module ffea_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [0:0]          cfg_idx,
	input  wire logic [31:0]         cfg_data,
	input  wire ffea_pkg::in_word_t  in_word,
	input  wire ffea_pkg::cmd_t      cmd,
	output ffea_pkg::sts_t           sts,
	output ffea_pkg::out_word_t      res
);
	logic [31:0] base_q, bytes_q;
	ffea_pkg::cnt_t count_q;
	logic        is_free_q, ovf_q;
	logic [31:0] need_q, addr_q, size_q;
	// latched entries: next (first at or above the block) and previous
	logic [31:0] cs_q, cl_q, ps_q, pl_q;
	logic        have_prev_q;
	ffea_pkg::out_word_t res_q;    // result being built

	logic           we;
	ffea_pkg::idx_t waddr;
	logic [31:0]    wds, wdl, rds, rdl;

	ffea_ram #(.WIDTH(32), .DEPTH(ffea_pkg::MAX_EXTENTS)) u_start (
		.clk, .we, .waddr, .wdata(wds), .raddr(cmd.idx), .rdata(rds));
	ffea_ram #(.WIDTH(32), .DEPTH(ffea_pkg::MAX_EXTENTS)) u_len (
		.clk, .we, .waddr, .wdata(wdl), .raddr(cmd.idx), .rdata(rdl));

	logic [33:0] need_w;
	assign need_w = (({2'b0, in_word.request_bytes} + 34'd3) & ~34'd3) + 34'd4;

	logic [32:0] pend, plen, bend, nlen, nend, all;
	assign pend = {1'b0, ps_q} + {1'b0, pl_q};
	assign plen = {1'b0, pl_q} + {1'b0, size_q};
	assign bend = {1'b0, addr_q} + {1'b0, size_q};
	assign nlen = {1'b0, cl_q} + {1'b0, size_q};
	assign nend = {1'b0, ps_q} + plen;
	assign all  = plen + {1'b0, cl_q};

	always_comb begin
		sts.is_free    = is_free_q;
		sts.need_ovf   = ovf_q;
		sts.size_zero  = (size_q == 32'd0);
		sts.fit        = (rdl >= need_q);
		sts.below      = (rds < addr_q);
		sts.prev_touch = have_prev_q && pend == {1'b0, addr_q} && !plen[32];
		sts.next_touch = bend == {1'b0, cs_q} && !nlen[32];
		sts.chain      = nend == {1'b0, cs_q} && !all[32];
		sts.empty_after = (rdl == need_q);
		sts.count      = count_q;
	end

	// table write port
	always_comb begin
		we = 1'b0; waddr = cmd.idx; wds = rds; wdl = rdl;
		unique case (cmd.op)
			ffea_pkg::OP_INIT: begin
				we = 1'b1; waddr = '0; wds = base_q; wdl = bytes_q;
			end
			ffea_pkg::OP_CARVE: begin
				we = 1'b1; wds = rds + need_q; wdl = rdl - need_q;
			end
			ffea_pkg::OP_SHIFT: begin
				we = 1'b1;
			end
			ffea_pkg::OP_SETLEN: begin
				we = 1'b1; wds = ps_q; wdl = plen[31:0];
			end
			ffea_pkg::OP_SETBOTH: begin
				we = 1'b1; wds = ps_q; wdl = all[31:0];
			end
			ffea_pkg::OP_SETNEXT: begin
				we = 1'b1; wds = addr_q; wdl = nlen[31:0];
			end
			ffea_pkg::OP_PUT: begin
				we = 1'b1; wds = addr_q; wdl = size_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0; bytes_q <= '0; count_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == ffea_pkg::REG_BASE) base_q <= cfg_data;
				else bytes_q <= cfg_data;
			end
			unique case (cmd.op)
				ffea_pkg::OP_INIT: count_q <= (bytes_q != '0) ? ffea_pkg::cnt_t'(1) : '0;
				ffea_pkg::OP_DEC:  count_q <= count_q - ffea_pkg::cnt_t'(1);
				ffea_pkg::OP_PUT:  count_q <= count_q + ffea_pkg::cnt_t'(1);
				default: ;
			endcase
		end
	end

	// operands, latched entries and result
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			ffea_pkg::OP_LOAD: begin
				is_free_q <= in_word.command == ffea_pkg::CMD_FREE;
				need_q <= need_w[31:0];
				ovf_q <= |need_w[33:32];
				addr_q <= in_word.free_pointer - ffea_pkg::HDR;
				size_q <= in_word.free_block_bytes;
				have_prev_q <= 1'b0;
				res_q <= '{32'd0, 32'd0, ffea_pkg::ST_OK};
			end
			ffea_pkg::OP_PREV: begin
				ps_q <= rds; pl_q <= rdl; have_prev_q <= 1'b1;
			end
			ffea_pkg::OP_CUR: begin
				cs_q <= rds; cl_q <= rdl;
			end
			ffea_pkg::OP_CARVE: begin
				res_q.user_pointer <= rds + ffea_pkg::HDR;
				res_q.granted_bytes <= need_q;
			end
			ffea_pkg::OP_NOFIT: res_q.status <= ffea_pkg::ST_NOFIT;
			ffea_pkg::OP_FULL:  res_q.status <= ffea_pkg::ST_FULL;
			ffea_pkg::OP_EMIT:  res <= res_q;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/ffea_ctrl.sv]
// Controller: sequences scan, carve, merge and shift steps over the table.
`default_nettype none
module ffea_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire ffea_pkg::sts_t sts,
	output ffea_pkg::cmd_t      cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_RD, S_CHK, S_DECIDE, S_REM, S_REMWR, S_INS, S_INSWR,
		S_DONE
	} state_t;

	state_t state_q;
	ffea_pkg::cnt_t i_q, k_q;
	ffea_pkg::cnt_t i_dec, k_inc, k_dec;
	logic cfg_pend_q, nxt_q;
	logic accept, out_free;

	// idle, no heap write and no table reload pending: take a word
	assign in_stall = !(state_q == S_IDLE && !cfg_pend_q && !cfg_we);
	assign accept = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	assign i_dec = i_q - ffea_pkg::cnt_t'(1);
	assign k_inc = k_q + ffea_pkg::cnt_t'(1);
	assign k_dec = k_q - ffea_pkg::cnt_t'(1);

	// operation and table address for the datapath
	always_comb begin
		cmd.op = ffea_pkg::OP_NONE;
		cmd.idx = ffea_pkg::idx_t'(i_q);
		unique case (state_q)
			S_IDLE: if (accept) cmd.op = ffea_pkg::OP_LOAD;
			S_INIT: cmd.op = ffea_pkg::OP_INIT;
			S_RD: begin
				if (!sts.is_free && (sts.need_ovf || i_q >= sts.count))
					cmd.op = ffea_pkg::OP_NOFIT;
			end
			S_CHK: begin
				if (!sts.is_free) begin
					if (sts.fit) cmd.op = ffea_pkg::OP_CARVE;
				end else if (sts.below) begin
					cmd.op = ffea_pkg::OP_PREV;
				end else begin
					cmd.op = ffea_pkg::OP_CUR;
				end
			end
			S_DECIDE: begin
				if (sts.prev_touch) begin
					cmd.idx = ffea_pkg::idx_t'(i_dec);
					if (nxt_q && sts.chain) cmd.op = ffea_pkg::OP_SETBOTH;
					else cmd.op = ffea_pkg::OP_SETLEN;
				end else if (nxt_q && sts.next_touch) begin
					cmd.op = ffea_pkg::OP_SETNEXT;
				end else if (sts.count >= ffea_pkg::cnt_t'(ffea_pkg::MAX_EXTENTS)) begin
					cmd.op = ffea_pkg::OP_FULL;
				end
			end
			S_REM: begin
				if (k_inc >= sts.count) cmd.op = ffea_pkg::OP_DEC;
				else cmd.idx = ffea_pkg::idx_t'(k_inc);
			end
			S_REMWR: begin cmd.op = ffea_pkg::OP_SHIFT; cmd.idx = ffea_pkg::idx_t'(k_q); end
			S_INS: begin
				if (k_q == i_q) cmd.op = ffea_pkg::OP_PUT;
				else cmd.idx = ffea_pkg::idx_t'(k_dec);
			end
			S_INSWR: begin cmd.op = ffea_pkg::OP_SHIFT; cmd.idx = ffea_pkg::idx_t'(k_q); end
			S_DONE: if (out_free) cmd.op = ffea_pkg::OP_EMIT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; i_q <= '0; k_q <= '0;
			cfg_pend_q <= 1'b0; nxt_q <= 1'b0;
		end else begin
			cfg_pend_q <= cfg_we || (cfg_pend_q && state_q != S_IDLE);
			if (state_q == S_DONE && out_free) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cfg_pend_q) begin
						state_q <= S_INIT;
					end else if (accept) begin
						i_q <= '0; nxt_q <= 1'b0; state_q <= S_RD;
					end
				end
				S_INIT: state_q <= S_IDLE;
				S_RD: begin
					if (!sts.is_free) begin
						if (sts.need_ovf || i_q >= sts.count) state_q <= S_DONE;
						else state_q <= S_CHK;
					end else if (sts.size_zero) begin
						state_q <= S_DONE;
					end else if (i_q >= sts.count) begin
						state_q <= S_DECIDE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!sts.is_free) begin
						if (sts.fit) begin
							if (sts.empty_after) begin
								k_q <= i_q; state_q <= S_REM;
							end else begin
								state_q <= S_DONE;
							end
						end else begin
							i_q <= i_q + ffea_pkg::cnt_t'(1); state_q <= S_RD;
						end
					end else if (sts.below) begin
						i_q <= i_q + ffea_pkg::cnt_t'(1); state_q <= S_RD;
					end else begin
						nxt_q <= 1'b1; state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (sts.prev_touch) begin
						if (nxt_q && sts.chain) begin
							k_q <= i_q; state_q <= S_REM;
						end else begin
							state_q <= S_DONE;
						end
					end else if (nxt_q && sts.next_touch) begin
						state_q <= S_DONE;
					end else if (sts.count >= ffea_pkg::cnt_t'(ffea_pkg::MAX_EXTENTS)) begin
						state_q <= S_DONE;
					end else begin
						k_q <= sts.count; state_q <= S_INS;
					end
				end
				S_REM: begin
					if (k_inc >= sts.count) state_q <= S_DONE;
					else state_q <= S_REMWR;
				end
				S_REMWR: begin k_q <= k_inc; state_q <= S_REM; end
				S_INS: begin
					if (k_q == i_q) state_q <= S_DONE;
					else state_q <= S_INSWR;
				end
				S_INSWR: begin k_q <= k_dec; state_q <= S_INS; end
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[tb/tb_first_fit_extent_allocator.sv]
// Testbench for the first-fit extent allocator: random and directed words checked against a model.
`timescale 1ns / 1ps
module tb_first_fit_extent_allocator;
	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	ffea_pkg::in_word_t in_data;
	logic out_valid;
	logic out_stall;
	ffea_pkg::out_word_t out_data;

	first_fit_extent_allocator i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// model state
	logic [31:0] m_base, m_bytes;
	logic [31:0] ext_start [ffea_pkg::MAX_EXTENTS];
	logic [31:0] ext_len [ffea_pkg::MAX_EXTENTS];
	int ext_cnt;

	ffea_pkg::in_word_t pending_words[$];
	ffea_pkg::out_word_t expected_results[$];
	// blocks handed out and not yet returned: {pointer, size}
	logic [63:0] live_blocks[$];
	int errors = 0;
	int cycle = 0;
	int n_alloc = 0, n_free = 0, n_nofit = 0, n_full = 0;
	bit no_idle = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > 2000000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void reload_table();
		ext_cnt = 0;
		if (m_bytes != 0) begin
			ext_start[0] = m_base;
			ext_len[0] = m_bytes;
			ext_cnt = 1;
		end
	endfunction

	function automatic void drop_extent(int i);
		for (int k = i; k + 1 < ext_cnt; k++) begin
			ext_start[k] = ext_start[k + 1];
			ext_len[k] = ext_len[k + 1];
		end
		if (ext_cnt > 0) ext_cnt--;
	endfunction

	// compute the result of one word and update the extent table
	function automatic ffea_pkg::out_word_t allocator_result(ffea_pkg::in_word_t w);
		ffea_pkg::out_word_t r;
		logic [33:0] need;
		logic [31:0] addr, blk;
		logic [32:0] pend, plen, nend, all, bend, nlen;
		int i, p;
		r = '0;
		r.status = ffea_pkg::ST_OK;
		if (w.command == ffea_pkg::CMD_ALLOC) begin
			need = ((34'(w.request_bytes) + 34'd3) & ~34'd3) + 34'd4;
			r.status = ffea_pkg::ST_NOFIT;
			if (need <= 34'hFFFFFFFF) begin
				for (i = 0; i < ext_cnt; i++) begin
					if (34'(ext_len[i]) >= need) begin
						blk = ext_start[i];
						ext_start[i] = blk + need[31:0];
						ext_len[i] = ext_len[i] - need[31:0];
						if (ext_len[i] == 0) drop_extent(i);
						r.user_pointer = blk + ffea_pkg::HDR;
						r.granted_bytes = need[31:0];
						r.status = ffea_pkg::ST_OK;
						break;
					end
				end
			end
			return r;
		end
		if (w.free_block_bytes == 0) return r;
		addr = w.free_pointer - ffea_pkg::HDR;
		i = 0;
		while (i < ext_cnt && ext_start[i] < addr) i++;
		if (i > 0) begin
			p = i - 1;
			pend = 33'(ext_start[p]) + 33'(ext_len[p]);
			plen = 33'(ext_len[p]) + 33'(w.free_block_bytes);
			if (pend == 33'(addr) && !plen[32]) begin
				ext_len[p] = plen[31:0];
				if (i < ext_cnt) begin
					nend = 33'(ext_start[p]) + plen;
					all = plen + 33'(ext_len[i]);
					if (nend == 33'(ext_start[i]) && !all[32]) begin
						ext_len[p] = all[31:0];
						drop_extent(i);
					end
				end
				return r;
			end
		end
		if (i < ext_cnt) begin
			bend = 33'(addr) + 33'(w.free_block_bytes);
			nlen = 33'(ext_len[i]) + 33'(w.free_block_bytes);
			if (bend == 33'(ext_start[i]) && !nlen[32]) begin
				ext_start[i] = addr;
				ext_len[i] = nlen[31:0];
				return r;
			end
		end
		if (ext_cnt >= ffea_pkg::MAX_EXTENTS) begin
			r.status = ffea_pkg::ST_FULL;
			return r;
		end
		for (int k = ext_cnt; k > i; k--) begin
			ext_start[k] = ext_start[k - 1];
			ext_len[k] = ext_len[k - 1];
		end
		ext_start[i] = addr;
		ext_len[i] = w.free_block_bytes;
		ext_cnt++;
		return r;
	endfunction

	// driver: present queued words, hold while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				ffea_pkg::out_word_t r;
				r = allocator_result(in_data);
				expected_results.push_back(r);
				if (in_data.command == ffea_pkg::CMD_ALLOC && r.status == ffea_pkg::ST_OK)
					live_blocks.push_back({r.user_pointer, r.granted_bytes});
			end
			if (!in_valid || !in_stall) begin
				if (pending_words.size() > 0 && (no_idle || $urandom_range(99) >= 28)) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each accepted result word with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result word %h", out_data);
					errors++;
				end else begin
					ffea_pkg::out_word_t e;
					e = expected_results.pop_front();
					if (out_data.user_pointer !== e.user_pointer) begin
						$error("user_pointer exp %h got %h", e.user_pointer,
							out_data.user_pointer);
						errors++;
					end
					if (out_data.granted_bytes !== e.granted_bytes) begin
						$error("granted_bytes exp %h got %h", e.granted_bytes,
							out_data.granted_bytes);
						errors++;
					end
					if (out_data.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, out_data.status);
						errors++;
					end
					if (e.status == ffea_pkg::ST_NOFIT) n_nofit++;
					if (e.status == ffea_pkg::ST_FULL) n_full++;
				end
			end
			out_stall <= !no_idle && ($urandom_range(99) < 28);
		end
	end

	task automatic wait_idle();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (3 * ffea_pkg::MAX_EXTENTS + 10) @(posedge clk);
	endtask

	// write enable stays high across back-to-back writes; set_heap drops it
	task automatic write_reg(logic [0:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == ffea_pkg::REG_BASE) m_base = val; else m_bytes = val;
		reload_table();
		live_blocks.delete();
	endtask

	task automatic set_heap(logic [31:0] b, logic [31:0] n);
		wait_idle();
		write_reg(ffea_pkg::REG_BASE, b);
		write_reg(ffea_pkg::REG_BYTES, n);
		cfg_we <= 1'b0;
	endtask

	function automatic ffea_pkg::in_word_t alloc_word(logic [31:0] req);
		ffea_pkg::in_word_t w;
		w = '0;
		w.command = ffea_pkg::CMD_ALLOC;
		w.request_bytes = req;
		w.free_pointer = $urandom;
		w.free_block_bytes = $urandom;
		n_alloc++;
		return w;
	endfunction

	function automatic ffea_pkg::in_word_t free_word(logic [31:0] p, logic [31:0] s);
		ffea_pkg::in_word_t w;
		w = '0;
		w.command = ffea_pkg::CMD_FREE;
		w.request_bytes = $urandom;
		w.free_pointer = p;
		w.free_block_bytes = s;
		n_free++;
		return w;
	endfunction

	// stimulus
	initial begin
		logic [63:0] blk;
		int j;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		m_base = 0;
		m_bytes = 0;
		reload_table();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset, then zero heap size
		pending_words.push_back(alloc_word(0));
		pending_words.push_back(free_word(32'h0, 32'h0));
		set_heap(32'h1000, 0);
		pending_words.push_back(alloc_word(8));
		// oversized requests, wrap of pointer - 4, merges and overflow guard
		set_heap(32'h1000, 32'h100);
		pending_words.push_back(alloc_word(32'hFFFFFFFF));
		pending_words.push_back(alloc_word(32'hFFFFFFF9));
		pending_words.push_back(alloc_word(1));
		pending_words.push_back(alloc_word(5));
		pending_words.push_back(alloc_word(32'h100));
		pending_words.push_back(free_word(32'h1004, 8));
		pending_words.push_back(free_word(32'h1010, 4));
		pending_words.push_back(free_word(32'h0, 4));
		pending_words.push_back(free_word(32'h2, 32'hFFFFFFFF));
		pending_words.push_back(free_word(32'h1004, 8));
		set_heap(32'hFFFFFF00, 32'hFFFFFFFF);
		pending_words.push_back(alloc_word(32'hFFFFFFF0));
		pending_words.push_back(free_word(32'hFFFFFF04, 32'h10));
		pending_words.push_back(alloc_word(32'h0));
		// fill the table to force a dropped block
		set_heap(32'h0, 32'h400);
		for (j = 0; j < ffea_pkg::MAX_EXTENTS + 2; j++)
			pending_words.push_back(free_word(32'h1000 + j * 32, 8));
		wait_idle();

		// random phases: allocations and frees of real blocks, some noise
		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph == 3);
			case (ph % 4)
				0: set_heap($urandom, $urandom_range(32'h2000, 32'h100));
				1: set_heap($urandom & 32'hFFFF_FFFC, $urandom_range(32'h400, 32'h40));
				2: set_heap(32'h0, 32'hFFFFFFFF);
				default: set_heap(32'hFFFF_FFFF, $urandom);
			endcase
			for (j = 0; j < 105; j++) begin
				int pick;
				pick = $urandom_range(99);
				if (pick < 45) begin
					pending_words.push_back(alloc_word(
						($urandom_range(99) < 5) ? $urandom : $urandom_range(64)));
				end else if (pick < 85 && live_blocks.size() > 0) begin
					int k;
					k = $urandom_range(live_blocks.size() - 1);
					blk = live_blocks[k];
					live_blocks.delete(k);
					pending_words.push_back(free_word(blk[63:32], blk[31:0]));
				end else begin
					pending_words.push_back(free_word($urandom,
						($urandom_range(1)) ? $urandom : $urandom_range(40)));
				end
				// live_blocks is filled at acceptance; let it catch up now and then
				if ($urandom_range(9) == 0)
					while (pending_words.size() > 0) @(posedge clk);
				if (ph == 5 && j == 50) wait_idle();
			end
		end
		wait_idle();
		no_idle = 0;

		$display("Covered %0d allocate and %0d free words, %0d no-fit, %0d table-full,",
			n_alloc, n_free, n_nofit, n_full);
		$display("over several heap settings with random stalls on both sides.");
		if (errors == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

[files.f]
rtl/ffea_pkg.sv
rtl/ffea_ram.sv
rtl/ffea_datapath.sv
rtl/ffea_ctrl.sv
rtl/first_fit_extent_allocator.sv
tb/tb_first_fit_extent_allocator.sv
